>>> rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Q16.16 operand and result beats, divider cell state, operation codes.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

  localparam int WIDTH     = 32;
  localparam int FRAC_BITS = 16;
  localparam int PW        = 2 * WIDTH;            // product width
  localparam int SW        = PW + 1;               // product sum width
  localparam int NW        = PW + FRAC_BITS + 1;   // dividend width
  localparam int DW        = PW + 1;               // divisor width
  localparam int QW        = WIDTH;                // quotient bits, one per cell
  localparam int NCELL     = QW;
  localparam int LATENCY   = 5 + NCELL + 1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [WIDTH-1:0] a_re;
    logic signed [WIDTH-1:0] a_im;
    logic signed [WIDTH-1:0] b_re;
    logic signed [WIDTH-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] c_re;
    logic signed [WIDTH-1:0] c_im;
    logic [1:0]              status;
  } rsp_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          dz;
    logic [DW-1:0] den;
    lane_t         re;
    lane_t         im;
  } cell_t;

endpackage
`default_nettype wire

>>> rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, multiply and divide in Q16.16
// Five setup stages feed a row of 32 division cells and a saturating output.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat on req is taken at a rising edge with start high and busy
//   low. req_type selects A+B, A-B, A*B or A/B on signed Q16.16 parts.
//   busy is high only while rst is high and in the cycle after it; the
//   block takes a new beat every cycle otherwise.
//   Every beat yields one result beat on rsp, shown for one cycle with done
//   high, after the five front stages, 32 cells and the output register.
//   Throughput is one beat per cycle while busy is low: each cell retires
//   one quotient bit per cycle; all operations share one row, so latency is fixed.
//   status: ok, divide by zero (result zero), or saturated.
//   Reset empties the pipeline; beats in flight are dropped. The receiver
//   cannot stall: results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arith_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cau_pkg::req_t  req,
  output logic               done,
  output cau_pkg::rsp_t       rsp
);

  logic           init;
  logic           accept;
  cau_pkg::cell_t chain [cau_pkg::NCELL+1];

  assign busy   = rst | init;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    init <= rst;
  end

  cau_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .dout   (chain[0])
  );

  for (genvar i = 0; i < cau_pkg::NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  localparam logic [cau_pkg::WIDTH-1:0] SMAX = {1'b0, {(cau_pkg::WIDTH-1){1'b1}}};
  localparam logic [cau_pkg::WIDTH-1:0] SMIN = {1'b1, {(cau_pkg::WIDTH-1){1'b0}}};

  function automatic logic [cau_pkg::WIDTH:0] clamp(cau_pkg::lane_t l);
    logic big;
    if (l.neg) begin
      big = l.ovf || (l.q[cau_pkg::QW-1] && (l.q[cau_pkg::QW-2:0] != '0));
      return big ? {1'b1, SMIN} : {1'b0, cau_pkg::WIDTH'(-l.q)};
    end
    big = l.ovf || l.q[cau_pkg::QW-1];
    return big ? {1'b1, SMAX} : {1'b0, cau_pkg::WIDTH'(l.q)};
  endfunction

  cau_pkg::cell_t           last;
  logic [cau_pkg::WIDTH:0]  cl_re, cl_im;

  assign last  = chain[cau_pkg::NCELL];
  assign cl_re = clamp(last.re);
  assign cl_im = clamp(last.im);

  always_ff @(posedge clk) begin
    if (last.dz) begin
      rsp.c_re   <= '0;
      rsp.c_im   <= '0;
      rsp.status <= cau_pkg::ST_DZ;
    end else begin
      rsp.c_re   <= cl_re[cau_pkg::WIDTH-1:0];
      rsp.c_im   <= cl_im[cau_pkg::WIDTH-1:0];
      rsp.status <= (cl_re[cau_pkg::WIDTH] | cl_im[cau_pkg::WIDTH]) ? cau_pkg::ST_SAT
                                                                  : cau_pkg::ST_OK;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(cau_pkg::LATENCY) done)
    else $error("result beat missing after fixed latency");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == cau_pkg::ST_DZ |-> rsp.c_re == '0 && rsp.c_im == '0)
    else $error("divide by zero beat with nonzero result");

  a_sat_ext: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == cau_pkg::ST_SAT |->
      rsp.c_re == SMAX || rsp.c_re == SMIN || rsp.c_im == SMAX || rsp.c_im == SMIN)
    else $error("saturated beat without a clamped part");
`endif

endmodule
`default_nettype wire

>>> rtl/core/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell: one restoring division step
// Shifts one dividend bit into each lane's remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cau_pkg::cell_t din,
  output cau_pkg::cell_t      dout
);

  function automatic cau_pkg::lane_t step(cau_pkg::lane_t l, logic [cau_pkg::DW-1:0] d);
    cau_pkg::lane_t r;
    logic [cau_pkg::DW:0] t;
    t = {l.rem, l.lo[cau_pkg::QW-1]};
    r = l;
    r.lo = {l.lo[cau_pkg::QW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      r.q = {l.q[cau_pkg::QW-2:0], 1'b1};
    end else begin
      r.q = {l.q[cau_pkg::QW-2:0], 1'b0};
    end
    r.rem = t[cau_pkg::DW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    dout.dz  <= din.dz;
    dout.den <= din.den;
    dout.re  <= step(din.re, din.den);
    dout.im  <= step(din.im, din.den);
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: products, sums and divider setup
// Five stages turning an operand beat into dividend, divisor and flags.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire cau_pkg::req_t  req,
  output cau_pkg::cell_t      dout
);

  // stage 1: products and add or subtract results
  logic                         v1;
  logic [1:0]                   op1;
  logic signed [cau_pkg::PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [cau_pkg::WIDTH:0] as_re, as_im;

  // stage 2: sums
  logic                          v2;
  logic [1:0]                    op2;
  logic signed [cau_pkg::SW-1:0] s_re, s_im;
  logic [cau_pkg::PW-1:0]        den2;

  // stage 3: magnitudes
  logic                   v3;
  logic [1:0]             op3;
  logic [cau_pkg::PW-1:0] m_re, m_im, den3;
  logic                   n_re, n_im;

  // stage 4: dividend and divisor
  logic                   v4, dz4;
  logic [cau_pkg::NW-1:0] nu_re, nu_im;
  logic [cau_pkg::DW-1:0] dv4;
  logic                   n4_re, n4_im;

  localparam logic [cau_pkg::SW-1:0] HALF = cau_pkg::SW'(1) << (cau_pkg::FRAC_BITS - 1);

  logic [cau_pkg::SW-1:0] r_re, r_im;
  logic [cau_pkg::NW-1:0] nu_re_next, nu_im_next;
  logic [cau_pkg::DW-1:0] dv_next;

  always_ff @(posedge clk) begin
    op1   <= req.req_type;
    p_rr  <= req.a_re * req.b_re;
    p_ii  <= req.a_im * req.b_im;
    p_ri  <= req.a_re * req.b_im;
    p_ir  <= req.a_im * req.b_re;
    sq_r  <= req.b_re * req.b_re;
    sq_i  <= req.b_im * req.b_im;
    if (req.req_type == cau_pkg::OP_SUB) begin
      as_re <= (cau_pkg::WIDTH+1)'(req.a_re) - (cau_pkg::WIDTH+1)'(req.b_re);
      as_im <= (cau_pkg::WIDTH+1)'(req.a_im) - (cau_pkg::WIDTH+1)'(req.b_im);
    end else begin
      as_re <= (cau_pkg::WIDTH+1)'(req.a_re) + (cau_pkg::WIDTH+1)'(req.b_re);
      as_im <= (cau_pkg::WIDTH+1)'(req.a_im) + (cau_pkg::WIDTH+1)'(req.b_im);
    end
  end

  always_ff @(posedge clk) begin
    op2  <= op1;
    den2 <= sq_r + sq_i;
    unique case (op1) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s_re <= cau_pkg::SW'(as_re);
        s_im <= cau_pkg::SW'(as_im);
      end
      cau_pkg::OP_MUL: begin
        s_re <= cau_pkg::SW'(p_rr) - cau_pkg::SW'(p_ii);
        s_im <= cau_pkg::SW'(p_ri) + cau_pkg::SW'(p_ir);
      end
      default: begin
        s_re <= cau_pkg::SW'(p_rr) + cau_pkg::SW'(p_ii);
        s_im <= cau_pkg::SW'(p_ir) - cau_pkg::SW'(p_ri);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op3  <= op2;
    den3 <= den2;
    n_re <= s_re[cau_pkg::SW-1];
    n_im <= s_im[cau_pkg::SW-1];
    m_re <= s_re[cau_pkg::SW-1] ? cau_pkg::PW'(-s_re) : cau_pkg::PW'(s_re);
    m_im <= s_im[cau_pkg::SW-1] ? cau_pkg::PW'(-s_im) : cau_pkg::PW'(s_im);
  end

  always_comb begin
    r_re = {1'b0, m_re} + HALF;
    r_im = {1'b0, m_im} + HALF;
    unique case (op3) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        nu_re_next = cau_pkg::NW'(m_re);
        nu_im_next = cau_pkg::NW'(m_im);
        dv_next    = cau_pkg::DW'(1);
      end
      cau_pkg::OP_MUL: begin
        nu_re_next = cau_pkg::NW'(r_re[cau_pkg::SW-1:cau_pkg::FRAC_BITS]);
        nu_im_next = cau_pkg::NW'(r_im[cau_pkg::SW-1:cau_pkg::FRAC_BITS]);
        dv_next    = cau_pkg::DW'(1);
      end
      default: begin
        // round to nearest: (2n + d) / 2d
        nu_re_next = (cau_pkg::NW'(m_re) << (cau_pkg::FRAC_BITS + 1)) + cau_pkg::NW'(den3);
        nu_im_next = (cau_pkg::NW'(m_im) << (cau_pkg::FRAC_BITS + 1)) + cau_pkg::NW'(den3);
        dv_next    = {den3, 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    nu_re <= nu_re_next;
    nu_im <= nu_im_next;
    dv4   <= dv_next;
    dz4   <= (op3 == cau_pkg::OP_DIV) && (den3 == '0);
    n4_re <= n_re;
    n4_im <= n_im;
  end

  // stage 5: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    dout.dz     <= dz4;
    dout.den    <= dv4;
    dout.re.neg <= n4_re;
    dout.im.neg <= n4_im;
    dout.re.ovf <= {(cau_pkg::DW+cau_pkg::QW-cau_pkg::NW)'(0), nu_re} >= {dv4, cau_pkg::QW'(0)};
    dout.im.ovf <= {(cau_pkg::DW+cau_pkg::QW-cau_pkg::NW)'(0), nu_im} >= {dv4, cau_pkg::QW'(0)};
    dout.re.rem <= cau_pkg::DW'(nu_re[cau_pkg::NW-1:cau_pkg::QW]);
    dout.im.rem <= cau_pkg::DW'(nu_im[cau_pkg::NW-1:cau_pkg::QW]);
    dout.re.lo  <= nu_re[cau_pkg::QW-1:0];
    dout.im.lo  <= nu_im[cau_pkg::QW-1:0];
    dout.re.q   <= '0;
    dout.im.q   <= '0;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

endmodule
`default_nettype wire
